// ===== src/gcs_pkg.sv =====
// shared types and constants of the grid circle spacing check
// field widths, register indexes, status codes, controller states and command/status structs
// no dependencies
package gcs_pkg;

   localparam int POS_W      = 24;
   localparam int RAD_W      = 16;
   localparam int INV_W      = 24;
   localparam int CELLS_W    = 6;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int ENTRY_W    = 2 * POS_W + RAD_W;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Z = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INV_CELL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CELLS_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CELLS_Z  = 3'd4;

   // reset values of the registers
   localparam logic [INV_W-1:0]   INV_CELL_RESET = 24'd65536;
   localparam logic [CELLS_W-1:0] CELLS_RESET    = 6'd32;

   // neighbour offset counter runs 0..2 on each axis
   localparam logic [1:0] NB_LAST = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_PLACED  = 2'd0,
      STATUS_OVERLAP = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIFF,
      ST_MULX,
      ST_MULZ,
      ST_CLAMP,
      ST_NB_FILL,
      ST_NB_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic load;
      logic diff;
      logic mul_x;
      logic mul_z;
      logic clamp_z;
      logic nb_next;
      logic slot_next;
      logic scan;
      logic home_sel;
      logic commit;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic nb_live;
      logic nb_last;
      logic slot_last;
      logic pipe_busy;
      logic out_free;
   } stat_type;

endpackage

// ===== src/gcs_if.sv =====
// valid/ready channel interfaces of the grid circle spacing check
// request, response and csr write channels; depends on gcs_pkg
interface gcs_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [gcs_pkg::POS_W-1:0]   pos_x;
   logic signed [gcs_pkg::POS_W-1:0]   pos_z;
   logic        [gcs_pkg::RAD_W-1:0]   radius;

   modport source (output valid, output pos_x, output pos_z, output radius, input ready);
   modport sink   (input valid, input pos_x, input pos_z, input radius, output ready);
endinterface

interface gcs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [gcs_pkg::STATUS_W-1:0]      status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface

interface gcs_csr_if;
   logic                              valid;
   logic                              ready;
   logic [gcs_pkg::CSR_IDX_W-1:0]     index;
   logic [gcs_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/gcs_ctrl.sv =====
// controller state machine of the grid circle spacing check
// sequences the reset sweep, mapping, neighbour scan, drain and commit; depends on gcs_pkg
module gcs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gcs_pkg::stat_type stat,
   output gcs_pkg::cmd_type  cmd
);

   gcs_pkg::state_type state_ff;
   gcs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gcs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gcs_pkg::ST_CLEAR: begin
            if (stat.clear_last) state_in = gcs_pkg::ST_IDLE;
         end
         gcs_pkg::ST_IDLE: begin
            if (req_valid) state_in = gcs_pkg::ST_DIFF;
         end
         gcs_pkg::ST_DIFF:    state_in = gcs_pkg::ST_MULX;
         gcs_pkg::ST_MULX:    state_in = gcs_pkg::ST_MULZ;
         gcs_pkg::ST_MULZ:    state_in = gcs_pkg::ST_CLAMP;
         gcs_pkg::ST_CLAMP:   state_in = gcs_pkg::ST_NB_FILL;
         gcs_pkg::ST_NB_FILL: state_in = gcs_pkg::ST_NB_CHECK;
         gcs_pkg::ST_NB_CHECK: begin
            priority if (stat.nb_live) state_in = gcs_pkg::ST_SCAN;
            else if (stat.nb_last)     state_in = gcs_pkg::ST_DRAIN;
            else                       state_in = gcs_pkg::ST_NB_FILL;
         end
         gcs_pkg::ST_SCAN: begin
            if (stat.slot_last) begin
               state_in = stat.nb_last ? gcs_pkg::ST_DRAIN : gcs_pkg::ST_NB_FILL;
            end
         end
         gcs_pkg::ST_DRAIN: begin
            if (!stat.pipe_busy) state_in = gcs_pkg::ST_DECIDE;
         end
         gcs_pkg::ST_DECIDE: begin
            if (stat.out_free) state_in = gcs_pkg::ST_IDLE;
         end
         default: state_in = gcs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         gcs_pkg::ST_CLEAR: cmd.clear = 1'b1;
         gcs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         gcs_pkg::ST_DIFF:    cmd.diff    = 1'b1;
         gcs_pkg::ST_MULX:    cmd.mul_x   = 1'b1;
         gcs_pkg::ST_MULZ:    cmd.mul_z   = 1'b1;
         gcs_pkg::ST_CLAMP:   cmd.clamp_z = 1'b1;
         gcs_pkg::ST_NB_FILL: cmd         = '0;
         gcs_pkg::ST_NB_CHECK: begin
            cmd.nb_next = !stat.nb_live && !stat.nb_last;
         end
         gcs_pkg::ST_SCAN: begin
            cmd.scan      = 1'b1;
            cmd.slot_next = !stat.slot_last;
            cmd.nb_next   = stat.slot_last && !stat.nb_last;
         end
         gcs_pkg::ST_DRAIN: cmd.home_sel = 1'b1;
         gcs_pkg::ST_DECIDE: begin
            cmd.home_sel = 1'b1;
            cmd.commit   = stat.out_free;
         end
         default: cmd = '0;
      endcase
   end

   // at most one datapath phase per cycle
   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.diff, cmd.mul_x, cmd.mul_z, cmd.clamp_z,
                cmd.scan, cmd.commit, cmd.clear}))
      else $error("gcs_ctrl: more than one datapath phase active");

endmodule

// ===== src/gcs_datapath.sv =====
// datapath of the grid circle spacing check
// csr registers, cell mapping, bucket fill and circle memories, overlap pipeline, result register
// depends on gcs_pkg and the channel interfaces in gcs_if
module gcs_datapath #(
   parameter int GRID_X_MAX   = 32,
   parameter int GRID_Z_MAX   = 32,
   parameter int BUCKET_DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gcs_pkg::cmd_type                  cmd,
   output gcs_pkg::stat_type                 stat,
   input  logic signed [gcs_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [gcs_pkg::POS_W-1:0]  req_pos_z,
   input  logic        [gcs_pkg::RAD_W-1:0]  req_radius,
   gcs_rsp_if.source                         rsp_if,
   gcs_csr_if.sink                           csr_if
);

   localparam int NUM_CELLS = GRID_X_MAX * GRID_Z_MAX;
   localparam int NUM_SLOTS = NUM_CELLS * BUCKET_DEPTH;
   localparam int XCW = (GRID_X_MAX > 1) ? $clog2(GRID_X_MAX) : 1;
   localparam int ZCW = (GRID_Z_MAX > 1) ? $clog2(GRID_Z_MAX) : 1;
   localparam int XNW = $clog2(GRID_X_MAX + 1);
   localparam int ZNW = $clog2(GRID_Z_MAX + 1);
   localparam int CAW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int SAW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int FW  = $clog2(BUCKET_DEPTH + 1);
   localparam int SW  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int PW  = gcs_pkg::POS_W;
   localparam int RW  = gcs_pkg::RAD_W;
   localparam int MW  = 2 * PW;

   // csr registers
   logic signed [PW-1:0]                org_x_ff;
   logic signed [PW-1:0]                org_z_ff;
   logic [gcs_pkg::INV_W-1:0]           inv_ff;
   logic [gcs_pkg::CELLS_W-1:0]         cells_x_ff;
   logic [gcs_pkg::CELLS_W-1:0]         cells_z_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff   <= '0;
         org_z_ff   <= '0;
         inv_ff     <= gcs_pkg::INV_CELL_RESET;
         cells_x_ff <= gcs_pkg::CELLS_RESET;
         cells_z_ff <= gcs_pkg::CELLS_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            gcs_pkg::REG_ORIGIN_X: org_x_ff   <= $signed(csr_if.data[PW-1:0]);
            gcs_pkg::REG_ORIGIN_Z: org_z_ff   <= $signed(csr_if.data[PW-1:0]);
            gcs_pkg::REG_INV_CELL: inv_ff     <= csr_if.data[gcs_pkg::INV_W-1:0];
            gcs_pkg::REG_CELLS_X:  cells_x_ff <= csr_if.data[gcs_pkg::CELLS_W-1:0];
            gcs_pkg::REG_CELLS_Z:  cells_z_ff <= csr_if.data[gcs_pkg::CELLS_W-1:0];
            default: ;
         endcase
      end
   end

   // cell counts in use: zero reads as one, above the grid reads as the grid
   logic [XNW-1:0] nx;
   logic [ZNW-1:0] nz;

   always_comb begin
      priority if (cells_x_ff == '0)            nx = XNW'(1);
      else if (32'(cells_x_ff) > GRID_X_MAX)    nx = XNW'(GRID_X_MAX);
      else                                      nx = XNW'(cells_x_ff);
      priority if (cells_z_ff == '0)            nz = ZNW'(1);
      else if (32'(cells_z_ff) > GRID_Z_MAX)    nz = ZNW'(GRID_Z_MAX);
      else                                      nz = ZNW'(cells_z_ff);
   end

   // latched transaction
   logic signed [PW-1:0] pos_x_ff;
   logic signed [PW-1:0] pos_z_ff;
   logic [RW-1:0]        rad_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_x_ff <= req_pos_x;
         pos_z_ff <= req_pos_z;
         rad_ff   <= req_radius;
      end
   end

   // cell mapping through one shared multiplier
   logic signed [PW:0]  dx_ff;
   logic signed [PW:0]  dz_ff;
   logic [MW-1:0]       prod_ff;
   logic [PW-1:0]       mul_a;
   logic [PW-1:0]       c_hi;
   logic [XCW-1:0]      cx_ff;
   logic [ZCW-1:0]      cz_ff;
   logic [XCW-1:0]      cx_clamp;
   logic [ZCW-1:0]      cz_clamp;

   always_comb begin
      if (cmd.mul_z) begin
         mul_a = (dz_ff > 0) ? dz_ff[PW-1:0] : '0;
      end else begin
         mul_a = (dx_ff > 0) ? dx_ff[PW-1:0] : '0;
      end
      c_hi     = prod_ff[MW-1:PW];
      cx_clamp = (c_hi > PW'(nx - XNW'(1))) ? XCW'(nx - XNW'(1)) : XCW'(c_hi);
      cz_clamp = (c_hi > PW'(nz - ZNW'(1))) ? ZCW'(nz - ZNW'(1)) : ZCW'(c_hi);
   end

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         dx_ff <= (PW+1)'(pos_x_ff) - (PW+1)'(org_x_ff);
         dz_ff <= (PW+1)'(pos_z_ff) - (PW+1)'(org_z_ff);
      end
      if (cmd.mul_x || cmd.mul_z) begin
         prod_ff <= MW'(mul_a) * MW'(inv_ff);
      end
      if (cmd.mul_z)   cx_ff <= cx_clamp;
      if (cmd.clamp_z) cz_ff <= cz_clamp;
   end

   // neighbour and slot counters
   logic [1:0]      nb_x_ff;
   logic [1:0]      nb_z_ff;
   logic [SW-1:0]   slot_ff;
   logic [CAW-1:0]  clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nb_x_ff    <= '0;
         nb_z_ff    <= '0;
         slot_ff    <= '0;
         clr_cnt_ff <= '0;
      end else begin
         if (cmd.load) begin
            nb_x_ff <= '0;
            nb_z_ff <= '0;
         end else if (cmd.nb_next) begin
            if (nb_x_ff == gcs_pkg::NB_LAST) begin
               nb_x_ff <= '0;
               nb_z_ff <= nb_z_ff + 2'd1;
            end else begin
               nb_x_ff <= nb_x_ff + 2'd1;
            end
         end
         if (cmd.load || cmd.nb_next) slot_ff <= '0;
         else if (cmd.slot_next)      slot_ff <= slot_ff + SW'(1);
         if (cmd.clear) clr_cnt_ff <= clr_cnt_ff + CAW'(1);
      end
   end

   // neighbour cell: position plus offset, one above the true cell
   logic [XCW+1:0]  xp;
   logic [ZCW+1:0]  zp;
   logic [XCW-1:0]  nb_cx;
   logic [ZCW-1:0]  nb_cz;
   logic            nb_in_grid;
   logic [CAW-1:0]  nb_cell;
   logic [CAW-1:0]  home_cell;

   always_comb begin
      xp         = (XCW+2)'(cx_ff) + (XCW+2)'(nb_x_ff);
      zp         = (ZCW+2)'(cz_ff) + (ZCW+2)'(nb_z_ff);
      nb_cx      = XCW'(xp - (XCW+2)'(1));
      nb_cz      = ZCW'(zp - (ZCW+2)'(1));
      nb_in_grid = (xp != '0) && (xp <= (XCW+2)'(nx)) && (zp != '0) && (zp <= (ZCW+2)'(nz));
      nb_cell    = CAW'(32'(nb_cz) * GRID_X_MAX + 32'(nb_cx));
      home_cell  = CAW'(32'(cz_ff) * GRID_X_MAX + 32'(cx_ff));
   end

   // bucket fill memory, swept to zero after reset
   logic [FW-1:0]   fill_mem [NUM_CELLS];
   logic [FW-1:0]   fill_q;
   logic [CAW-1:0]  fill_raddr;
   logic [CAW-1:0]  fill_waddr;
   logic [FW-1:0]   fill_wdata;
   logic            fill_we;
   logic            hit_ff;
   logic            placed;

   assign placed     = !hit_ff && (32'(fill_q) < BUCKET_DEPTH);
   assign fill_raddr = cmd.home_sel ? home_cell : nb_cell;
   assign fill_we    = cmd.clear || (cmd.commit && placed);
   assign fill_waddr = cmd.clear ? clr_cnt_ff : home_cell;
   assign fill_wdata = cmd.clear ? '0 : fill_q + FW'(1);

   always_ff @(posedge clock) begin
      if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
      fill_q <= fill_mem[fill_raddr];
   end

   // circle store: {radius, pos_z, pos_x} per slot
   logic [gcs_pkg::ENTRY_W-1:0] store_mem [NUM_SLOTS];
   logic [gcs_pkg::ENTRY_W-1:0] entry_q;
   logic [SAW-1:0]              store_raddr;
   logic [SAW-1:0]              store_waddr;

   assign store_raddr = SAW'(32'(nb_cell) * BUCKET_DEPTH + 32'(slot_ff));
   assign store_waddr = SAW'(32'(home_cell) * BUCKET_DEPTH + 32'(fill_q));

   always_ff @(posedge clock) begin
      if (cmd.commit && placed) begin
         store_mem[store_waddr] <= {rad_ff, pos_z_ff, pos_x_ff};
      end
      entry_q <= store_mem[store_raddr];
   end

   // overlap pipeline: read, differences, squares, compare
   logic                s1_valid_ff;
   logic                s2_valid_ff;
   logic                s3_valid_ff;
   logic [PW-1:0]       ax_ff;
   logic [PW-1:0]       az_ff;
   logic [RW:0]         rsum_ff;
   logic [MW-1:0]       sqx_ff;
   logic [MW-1:0]       sqz_ff;
   logic [2*RW+1:0]     sqr_ff;
   logic signed [PW:0]  ddx;
   logic signed [PW:0]  ddz;
   logic                overlap;

   always_comb begin
      ddx     = (PW+1)'(pos_x_ff) - (PW+1)'($signed(entry_q[PW-1:0]));
      ddz     = (PW+1)'(pos_z_ff) - (PW+1)'($signed(entry_q[2*PW-1:PW]));
      overlap = ((MW+1)'(sqx_ff) + (MW+1)'(sqz_ff)) < (MW+1)'(sqr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.scan;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (cmd.load)                   hit_ff <= 1'b0;
         else if (s3_valid_ff && overlap) hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff   <= (ddx < 0) ? PW'(-ddx) : PW'(ddx);
      az_ff   <= (ddz < 0) ? PW'(-ddz) : PW'(ddz);
      rsum_ff <= (RW+1)'(rad_ff) + (RW+1)'(entry_q[gcs_pkg::ENTRY_W-1:2*PW]);
      sqx_ff  <= MW'(ax_ff) * MW'(ax_ff);
      sqz_ff  <= MW'(az_ff) * MW'(az_ff);
      sqr_ff  <= (2*RW+2)'(rsum_ff) * (2*RW+2)'(rsum_ff);
   end

   // result register
   logic                 out_valid_ff;
   gcs_pkg::status_type  out_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         priority if (hit_ff)   out_status_ff <= gcs_pkg::STATUS_OVERLAP;
         else if (!placed)      out_status_ff <= gcs_pkg::STATUS_FULL;
         else                   out_status_ff <= gcs_pkg::STATUS_PLACED;
      end
   end

   assign rsp_if.valid  = out_valid_ff;
   assign rsp_if.status = out_status_ff;

   // status to the controller
   logic [FW-1:0] slot_ext;

   assign slot_ext        = FW'(slot_ff);
   assign stat.clear_last = (clr_cnt_ff == CAW'(NUM_CELLS - 1));
   assign stat.nb_live    = nb_in_grid && (fill_q != '0);
   assign stat.nb_last    = (nb_x_ff == gcs_pkg::NB_LAST) && (nb_z_ff == gcs_pkg::NB_LAST);
   assign stat.slot_last  = (slot_ext + FW'(1)) == fill_q;
   assign stat.pipe_busy  = s1_valid_ff || s2_valid_ff || s3_valid_ff;
   assign stat.out_free   = !out_valid_ff || rsp_if.ready;

   a_commit_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !stat.pipe_busy)
      else $error("gcs_datapath: commit with overlap checks still in flight");

   a_scan_live_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> (nb_in_grid && (slot_ext < fill_q)))
      else $error("gcs_datapath: scan of an empty slot or an off-grid cell");

   a_commit_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> out_valid_ff)
      else $error("gcs_datapath: commit did not load the result register");

endmodule

// ===== src/grid_circle_spacing_check.sv =====
// top level of the grid circle spacing check
// joins gcs_ctrl and gcs_datapath to the request, response and csr channels
// depends on gcs_pkg, gcs_if, gcs_ctrl, gcs_datapath
//
// usage
//  - req_if carries one circle per transaction: centre pos_x/pos_z (signed q16.8)
//    and radius (unsigned q8.8); rsp_if returns one 2-bit status per circle:
//    placed and stored, overlaps a stored circle, or home bucket full
//  - csr_if writes origin_x, origin_z, inv_cell, cells_x, cells_z by index; it is
//    always ready and is meant to be written only while no circle is in flight
//  - after reset the bucket fill memory is swept to zero, one cell per cycle,
//    across all GRID_X_MAX*GRID_Z_MAX cells (1024 by default); req_if.ready stays low meanwhile
//  - one circle at a time: cell mapping on a shared 24x24 multiplier, then a fill
//    read for each of the 9 neighbour cells, stored circles read one per cycle,
//    the home fill read while the overlap pipeline drains, and the commit
//  - the circles read are those in the 3x3 neighbourhood (up to 9*BUCKET_DEPTH);
//    the next request is taken after commit
//  - the result sits in an output register; a stalled receiver does not block the
//    next request, only the commit of the one after it waits for that register
module grid_circle_spacing_check #(
   parameter int GRID_X_MAX   = 32,
   parameter int GRID_Z_MAX   = 32,
   parameter int BUCKET_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   gcs_req_if.sink    req_if,
   gcs_rsp_if.source  rsp_if,
   gcs_csr_if.sink    csr_if
);

   // command and status between controller and datapath
   gcs_pkg::cmd_type  cmd;
   gcs_pkg::stat_type stat;
   logic              req_ready;

   // request ready only in the controller idle state
   assign req_if.ready = req_ready;

   gcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath holds the csr registers, both memories and the result register
   gcs_datapath #(
      .GRID_X_MAX   (GRID_X_MAX),
      .GRID_Z_MAX   (GRID_Z_MAX),
      .BUCKET_DEPTH (BUCKET_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_pos_x  (req_if.pos_x),
      .req_pos_z  (req_if.pos_z),
      .req_radius (req_if.radius),
      .rsp_if     (rsp_if),
      .csr_if     (csr_if)
   );

endmodule
